[design/psh_pkg.sv]
// Shared types and constants for the PC sample histogram core.
// No dependencies; used by psh_front, psh_back and the top level.
package psh_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_REPORT  = 12;
  localparam int LIM_W       = 4;
  localparam int TAG_W       = 26;
  localparam int PC_W        = 32;
  localparam int HITS_W      = 32;
  localparam int LSB_W       = PC_W - TAG_W;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_REPORT);

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic             op;
    logic [TAG_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

[design/pc_sample_histogram_core.sv]
// Record: linear search over the used entries, one table read per cycle.
// Report: up to report_limit passes over the used entries, one max scan per
// pass over the single table read port; beats leave one per pass.
// A two-deep command queue accepts new beats while the back end works.
// Reset (synchronous, active low) clears control, the fill count and the total;
// table memory is not swept. Results cannot be stalled by the receiver.
module pc_sample_histogram_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [psh_pkg::PC_W-1:0]    in_sample_pc,
  input  logic                        cfg_we,
  input  logic [psh_pkg::LIM_W-1:0]   cfg_data,
  output logic                        out_strobe,
  output logic                        out_entry_valid,
  output logic [psh_pkg::PC_W-1:0]    out_bucket_address,
  output logic [psh_pkg::HITS_W-1:0]  out_hit_count,
  output logic [psh_pkg::HITS_W-1:0]  out_total_samples,
  output logic                        out_last
);

  psh_pkg::queue_head_t head;
  logic                 pop;

  psh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_sample_pc (in_sample_pc),
    .head         (head),
    .pop          (pop)
  );

  psh_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_entry_valid    (out_entry_valid),
    .out_bucket_address (out_bucket_address),
    .out_hit_count      (out_hit_count),
    .out_total_samples  (out_total_samples),
    .out_last           (out_last)
  );

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_entry_valid) |-> out_last)
    else $error("invalid report beat not marked last");

  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_entry_valid) |-> (out_hit_count != '0))
    else $error("reported bucket with zero count");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("queue popped while empty");
`endif

endmodule

[design/psh_front.sv]
// Front end: takes command beats, reduces the PC to a bucket tag and queues
// them for the back end. Depends on psh_pkg.
module psh_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [psh_pkg::PC_W-1:0]  in_sample_pc,
  output psh_pkg::queue_head_t      head,
  input  logic                      pop
);

  psh_pkg::item_t q_mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           do_pop;
  psh_pkg::item_t new_item;

  assign busy   = (count_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    new_item.op  = in_operation;
    new_item.tag = in_sample_pc[psh_pkg::PC_W-1:psh_pkg::LSB_W];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_comb begin
    head.valid = (count_r != 2'd0);
    head.item  = q_mem_r[rd_ptr_r];
  end

endmodule

[design/psh_back.sv]
// Back end: table memories, linear search for records and repeated max scans
// for reports, plus the result register. Depends on psh_pkg.
module psh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psh_pkg::queue_head_t        head,
  output logic                        pop,
  input  logic                        cfg_we,
  input  logic [psh_pkg::LIM_W-1:0]   cfg_data,
  output logic                        out_strobe,
  output logic                        out_entry_valid,
  output logic [psh_pkg::PC_W-1:0]    out_bucket_address,
  output logic [psh_pkg::HITS_W-1:0]  out_hit_count,
  output logic [psh_pkg::HITS_W-1:0]  out_total_samples,
  output logic                        out_last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RSCAN = 4'b0010,
    S_PSCAN = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  localparam logic [psh_pkg::HITS_W-1:0] COUNT_MAX = '1;

  logic [psh_pkg::TAG_W-1:0]  tag_mem  [psh_pkg::TABLE_DEPTH];
  logic [psh_pkg::HITS_W-1:0] hits_mem [psh_pkg::TABLE_DEPTH];

  state_t                     state_r, state_nxt;
  logic [psh_pkg::LIM_W-1:0]  cfg_limit_r;
  logic [psh_pkg::LIM_W-1:0]  lim_r, lim_nxt;
  logic [psh_pkg::LIM_W-1:0]  n_r, n_nxt;
  logic [psh_pkg::CNT_W-1:0]  used_r, used_nxt;
  logic [psh_pkg::HITS_W-1:0] total_r, total_nxt;
  logic [psh_pkg::TAG_W-1:0]  tag_r, tag_nxt;
  logic [psh_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                       cmp_v_r, cmp_v_nxt;
  logic [psh_pkg::ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                       found_r, found_nxt;
  logic [psh_pkg::ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic [psh_pkg::TAG_W-1:0]  best_tag_r, best_tag_nxt;
  logic [psh_pkg::HITS_W-1:0] best_hits_r, best_hits_nxt;
  logic                       pend_v_r, pend_v_nxt;
  logic [psh_pkg::TAG_W-1:0]  pend_tag_r, pend_tag_nxt;
  logic [psh_pkg::HITS_W-1:0] pend_hits_r, pend_hits_nxt;

  logic [psh_pkg::TAG_W-1:0]  rd_tag_r;
  logic [psh_pkg::HITS_W-1:0] rd_hits_r;
  logic [psh_pkg::ADDR_W-1:0] rd_addr;

  logic                       mem_we;
  logic [psh_pkg::ADDR_W-1:0] mem_waddr;
  logic                       mem_wtag_en;
  logic [psh_pkg::TAG_W-1:0]  mem_wtag;
  logic [psh_pkg::HITS_W-1:0] mem_whits;

  logic                       strobe_r, strobe_nxt;
  logic                       ovalid_r, ovalid_nxt;
  logic [psh_pkg::TAG_W-1:0]  otag_r, otag_nxt;
  logic [psh_pkg::HITS_W-1:0] ohits_r, ohits_nxt;
  logic [psh_pkg::HITS_W-1:0] ototal_r, ototal_nxt;
  logic                       olast_r, olast_nxt;

  logic                       issue;
  logic [psh_pkg::LIM_W-1:0]  eff_limit;
  logic [psh_pkg::LIM_W-1:0]  n_inc;

  assign issue   = (idx_r < used_r);
  assign rd_addr = idx_r[psh_pkg::ADDR_W-1:0];
  assign n_inc   = n_r + psh_pkg::LIM_W'(1);

  always_comb begin
    if (cfg_limit_r == '0) begin
      eff_limit = psh_pkg::LIM_W'(1);
    end else if (cfg_limit_r > psh_pkg::LIM_W'(psh_pkg::MAX_REPORT)) begin
      eff_limit = psh_pkg::LIM_W'(psh_pkg::MAX_REPORT);
    end else begin
      eff_limit = cfg_limit_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    n_nxt         = n_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    tag_nxt       = tag_r;
    idx_nxt       = idx_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_tag_nxt  = best_tag_r;
    best_hits_nxt = best_hits_r;
    pend_v_nxt    = pend_v_r;
    pend_tag_nxt  = pend_tag_r;
    pend_hits_nxt = pend_hits_r;
    mem_we        = 1'b0;
    mem_waddr     = cmp_idx_r;
    mem_wtag_en   = 1'b0;
    mem_wtag      = tag_r;
    mem_whits     = '0;
    pop           = 1'b0;
    strobe_nxt    = 1'b0;
    ovalid_nxt    = ovalid_r;
    otag_nxt      = otag_r;
    ohits_nxt     = ohits_r;
    ototal_nxt    = ototal_r;
    olast_nxt     = olast_r;

    // one table read issued per cycle, compared in the cycle after
    if (state_r == S_RSCAN || state_r == S_PSCAN) begin
      cmp_v_nxt   = issue;
      cmp_idx_nxt = rd_addr;
      if (issue) begin
        idx_nxt = idx_r + psh_pkg::CNT_W'(1);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          tag_nxt   = head.item.tag;
          idx_nxt   = '0;
          cmp_v_nxt = 1'b0;
          if (head.item.op == psh_pkg::OP_RECORD) begin
            if (total_r != COUNT_MAX) begin
              total_nxt = total_r + psh_pkg::HITS_W'(1);
            end
            state_nxt = S_RSCAN;
          end else begin
            lim_nxt    = eff_limit;
            n_nxt      = '0;
            pend_v_nxt = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = S_PSCAN;
          end
        end
      end
      S_RSCAN: begin
        if (cmp_v_r && rd_tag_r == tag_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r;
          mem_whits = (rd_hits_r != COUNT_MAX) ? rd_hits_r + psh_pkg::HITS_W'(1) : rd_hits_r;
          state_nxt = S_IDLE;
        end else if (!cmp_v_r && !issue) begin
          // miss: append when there is room, else drop
          if (used_r < psh_pkg::CNT_W'(psh_pkg::TABLE_DEPTH)) begin
            mem_we      = 1'b1;
            mem_waddr   = used_r[psh_pkg::ADDR_W-1:0];
            mem_wtag_en = 1'b1;
            mem_wtag    = tag_r;
            mem_whits   = psh_pkg::HITS_W'(1);
            used_nxt    = used_r + psh_pkg::CNT_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_PSCAN: begin
        if (cmp_v_r) begin
          // strict compare keeps the lowest index on ties
          if (rd_hits_r != '0 && (!found_r || rd_hits_r > best_hits_r)) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = cmp_idx_r;
            best_tag_nxt  = rd_tag_r;
            best_hits_nxt = rd_hits_r;
          end
        end else if (!issue) begin
          // pass finished; the held beat learns here whether it is last
          if (found_r) begin
            if (pend_v_r) begin
              strobe_nxt = 1'b1;
              ovalid_nxt = 1'b1;
              otag_nxt   = pend_tag_r;
              ohits_nxt  = pend_hits_r;
              ototal_nxt = total_r;
              olast_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_tag_nxt  = best_tag_r;
            pend_hits_nxt = best_hits_r;
            mem_we        = 1'b1;
            mem_waddr     = best_idx_r;
            mem_whits     = '0;
            n_nxt         = n_inc;
            if (n_inc == lim_r) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt   = '0;
              cmp_v_nxt = 1'b0;
              found_nxt = 1'b0;
            end
          end else begin
            strobe_nxt = 1'b1;
            ovalid_nxt = pend_v_r;
            otag_nxt   = pend_v_r ? pend_tag_r : '0;
            ohits_nxt  = pend_v_r ? pend_hits_r : '0;
            ototal_nxt = total_r;
            olast_nxt  = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        strobe_nxt = 1'b1;
        ovalid_nxt = 1'b1;
        otag_nxt   = pend_tag_r;
        ohits_nxt  = pend_hits_r;
        ototal_nxt = total_r;
        olast_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_limit_r <= psh_pkg::LIMIT_RESET;
      used_r      <= '0;
      total_r     <= '0;
      cmp_v_r     <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
      cmp_v_r  <= cmp_v_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) begin
        cfg_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r       <= lim_nxt;
    n_r         <= n_nxt;
    tag_r       <= tag_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_tag_r  <= best_tag_nxt;
    best_hits_r <= best_hits_nxt;
    pend_v_r    <= pend_v_nxt;
    pend_tag_r  <= pend_tag_nxt;
    pend_hits_r <= pend_hits_nxt;
    ovalid_r    <= ovalid_nxt;
    otag_r      <= otag_nxt;
    ohits_r     <= ohits_nxt;
    ototal_r    <= ototal_nxt;
    olast_r     <= olast_nxt;
  end

  // table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hits_mem[mem_waddr] <= mem_whits;
      if (mem_wtag_en) begin
        tag_mem[mem_waddr] <= mem_wtag;
      end
    end
    rd_tag_r  <= tag_mem[rd_addr];
    rd_hits_r <= hits_mem[rd_addr];
  end

  assign out_strobe         = strobe_r;
  assign out_entry_valid    = ovalid_r;
  assign out_bucket_address = {otag_r, {psh_pkg::LSB_W{1'b0}}};
  assign out_hit_count      = ohits_r;
  assign out_total_samples  = ototal_r;
  assign out_last           = olast_r;

endmodule
